// ----- sv/sse_pkg.sv -----
// Shared types for the selection sort engine: input and result item layouts.
// No dependencies.
`timescale 1ns / 1ps

package sse_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_batch;
    logic                     overflow;
  } out_item_t;

endpackage

// ----- sv/sse_store.sv -----
// Batch store of the selection sort engine: one write port and one read port
// with registered read data. Uses sse_pkg for the data width.
`timescale 1ns / 1ps

module sse_store #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [ADDR_W-1:0]                wr_addr,
  input  logic signed [sse_pkg::DATA_W-1:0] wr_data,
  input  logic                             rd_en,
  input  logic [ADDR_W-1:0]                rd_addr,
  output logic signed [sse_pkg::DATA_W-1:0] rd_data
);

  logic signed [sse_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [sse_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/selection_sort_engine.sv -----
// Selection sort engine top level: load, sort and emit control around the
// batch store. Uses sse_pkg types and the sse_store memory.
//
// Usage: signed values arrive one per item on in_item (valid/ready). Items are
// written to the store until one marked last arrives; items past CAPACITY are
// dropped and flag the batch as overflowed. The batch is then sorted in place
// in ascending signed order and every entry leaves on out_item, the final one
// with end_of_batch set and all with the batch's overflow flag.
// Flow: loading accepts an item on each in_valid/in_ready handshake. For
// each position p below n-1, sorting reads store entries p through n-1 and
// then spends a drain step and two swap writes; its pace is set by the single
// read port of the store. Emission reads each result, then loads the output
// register. in_ready is high only while loading; the output register
// may still hold the previous batch's final item while the next batch loads.
// A stalled receiver holds the output register and pauses emission; nothing
// is lost. Synchronous reset empties the batch and the output register; store
// contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module selection_sort_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sse_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sse_pkg::out_item_t out_item
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    S_LOAD     = 7'b0000001,
    S_SCAN     = 7'b0000010,
    S_SCAN_END = 7'b0000100,
    S_SWAP_MIN = 7'b0001000,
    S_SWAP_POS = 7'b0010000,
    S_EMIT_RD  = 7'b0100000,
    S_EMIT_LD  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic [AW-1:0] min_idx_r, min_idx_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic signed [sse_pkg::DATA_W-1:0] min_val_r, min_val_nxt;
  logic signed [sse_pkg::DATA_W-1:0] pos_val_r, pos_val_nxt;
  logic                out_valid_r, out_valid_nxt;
  sse_pkg::out_item_t  out_item_r, out_item_nxt;

  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic signed [sse_pkg::DATA_W-1:0] wr_data;
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic signed [sse_pkg::DATA_W-1:0] rd_data;

  logic          in_acc;
  logic [AW-1:0] last_idx;
  logic          emit_last;

  sse_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign last_idx  = AW'(count_r - CW'(1));
  assign emit_last = ((CW'(k_r) + CW'(1)) == count_r);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    pos_nxt       = pos_r;
    scan_nxt      = scan_r;
    min_idx_nxt   = min_idx_r;
    min_val_nxt   = min_val_r;
    pos_val_nxt   = pos_val_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = 1'b0;
    k_nxt         = k_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = in_item.value;
    rd_en         = 1'b0;
    rd_addr       = scan_r;

    // Fold a returning scan read into the running minimum; first of equals wins.
    if (rd_vld_r) begin
      if (rd_idx_r == pos_r) begin
        min_val_nxt = rd_data;
        min_idx_nxt = rd_idx_r;
        pos_val_nxt = rd_data;
      end else if (rd_data < min_val_r) begin
        min_val_nxt = rd_data;
        min_idx_nxt = rd_idx_r;
      end
    end

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (count_r < CW'(CAPACITY)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_item.last) begin
            pos_nxt  = '0;
            scan_nxt = '0;
            k_nxt    = '0;
            if (count_nxt >= CW'(2)) begin
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_EMIT_RD;
            end
          end
        end
      end
      S_SCAN: begin
        rd_en      = 1'b1;
        rd_addr    = scan_r;
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = scan_r;
        scan_nxt   = scan_r + AW'(1);
        if (scan_r == last_idx) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_nxt = S_SWAP_MIN;
      end
      S_SWAP_MIN: begin
        wr_en     = 1'b1;
        wr_addr   = min_idx_r;
        wr_data   = pos_val_r;
        state_nxt = S_SWAP_POS;
      end
      S_SWAP_POS: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = min_val_r;
        if ((CW'(pos_r) + CW'(2)) == count_r) begin
          state_nxt = S_EMIT_RD;
        end else begin
          pos_nxt   = pos_r + AW'(1);
          scan_nxt  = pos_r + AW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_EMIT_RD: begin
        // Issue the read only when the output register is free next cycle.
        if (!out_valid_r || out_ready) begin
          rd_en     = 1'b1;
          rd_addr   = k_r;
          state_nxt = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        out_item_nxt.sorted_value = rd_data;
        out_item_nxt.end_of_batch = emit_last;
        out_item_nxt.overflow     = dropped_r;
        out_valid_nxt             = 1'b1;
        if (emit_last) begin
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          state_nxt   = S_LOAD;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      pos_r       <= '0;
      scan_r      <= '0;
      k_r         <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      pos_r       <= pos_nxt;
      scan_r      <= scan_nxt;
      k_r         <= k_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_idx_r  <= min_idx_nxt;
    min_val_r  <= min_val_nxt;
    pos_val_r  <= pos_val_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
